/* hw/rtl/mexp_pkg.sv */
`default_nettype none

package mexp_pkg;

  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned CNT_BITS  = $clog2(WORD_BITS);

  localparam logic [0:0] REG_EXPONENT = 1'b0;
  localparam logic [0:0] REG_MODULUS  = 1'b1;

  typedef struct packed {
    logic [31:0] base_value;
    logic        last_element;
  } in_req_t;

  typedef struct packed {
    logic [31:0] power_result;
    logic        last_out;
  } out_req_t;

  typedef struct packed {
    logic                load;
    logic                red_step;
    logic                ld_sq;
    logic                ld_mul;
    logic                mul_step;
    logic                mul_last;
    logic                out_load;
    logic [CNT_BITS-1:0] ebit;
  } cmd_t;

  typedef struct packed {
    logic exp_zero;
    logic mod_le1;
    logic exp_bit;
  } status_t;

  // Sum of two residues below m, reduced once.
  function automatic logic [WORD_BITS-1:0] add_mod(input logic [WORD_BITS-1:0] x,
                                                   input logic [WORD_BITS-1:0] y,
                                                   input logic [WORD_BITS-1:0] m);
    logic [WORD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[WORD_BITS-1:0];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/mexp_datapath.sv */
`default_nettype none

module mexp_datapath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_write_i,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i,
  input  wire mexp_pkg::in_req_t  in_data_i,
  input  wire mexp_pkg::cmd_t     cmd_i,
  output mexp_pkg::status_t       status_o,
  output mexp_pkg::out_req_t      out_data_o
);

  localparam int unsigned W = mexp_pkg::WORD_BITS;

  logic [W-1:0] exp_q, mod_q;
  logic [W-1:0] r_q, b_q, acc_q, mcand_q, mplr_q;
  logic [W-1:0] acc_d, dbl;
  logic [W:0]   red_s;
  logic [W-1:0] red_d;
  logic         last_q;
  mexp_pkg::out_req_t out_q;

  assign status_o.exp_zero = (exp_q == '0);
  assign status_o.mod_le1  = (mod_q[W-1:1] == '0);
  assign status_o.exp_bit  = exp_q[cmd_i.ebit];

  always_comb begin
    dbl   = mexp_pkg::add_mod(acc_q, acc_q, mod_q);
    acc_d = mplr_q[W-1] ? mexp_pkg::add_mod(dbl, mcand_q, mod_q) : dbl;
    red_s = {b_q, mplr_q[W-1]};
    if (red_s >= {1'b0, mod_q}) begin
      red_s = red_s - {1'b0, mod_q};
    end
    red_d = red_s[W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_q <= '0;
      mod_q <= {{(W-1){1'b0}}, 1'b1};
    end else if (cfg_write_i) begin
      unique case (cfg_index_i)
        mexp_pkg::REG_EXPONENT: exp_q <= cfg_data_i[W-1:0];
        mexp_pkg::REG_MODULUS:  mod_q <= cfg_data_i[W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mplr_q <= in_data_i.base_value[W-1:0];
      b_q    <= '0;
      r_q    <= {{(W-1){1'b0}}, status_o.exp_zero | ~status_o.mod_le1};
      last_q <= in_data_i.last_element;
    end
    if (cmd_i.red_step) begin
      b_q    <= red_d;
      mplr_q <= {mplr_q[W-2:0], 1'b0};
    end
    if (cmd_i.ld_sq) begin
      acc_q   <= '0;
      mcand_q <= r_q;
      mplr_q  <= r_q;
    end
    if (cmd_i.ld_mul) begin
      acc_q   <= '0;
      mcand_q <= b_q;
      mplr_q  <= r_q;
    end
    if (cmd_i.mul_step) begin
      acc_q  <= acc_d;
      mplr_q <= {mplr_q[W-2:0], 1'b0};
      if (cmd_i.mul_last) begin
        r_q <= acc_d;
      end
    end
    if (cmd_i.out_load) begin
      out_q.power_result <= r_q;
      out_q.last_out     <= last_q;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

/* hw/rtl/mexp_controller.sv */
`default_nettype none

module mexp_controller (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_ready_o,
  output logic               out_valid_o,
  input  wire logic          out_ready_i,
  input  wire mexp_pkg::status_t status_i,
  output mexp_pkg::cmd_t     cmd_o
);

  localparam int unsigned CB = mexp_pkg::CNT_BITS;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_RED    = 3'd1;
  localparam logic [2:0] S_LD_SQ  = 3'd2;
  localparam logic [2:0] S_SQ     = 3'd3;
  localparam logic [2:0] S_LD_MUL = 3'd4;
  localparam logic [2:0] S_MUL    = 3'd5;
  localparam logic [2:0] S_FIN    = 3'd6;

  logic [2:0]    state_q, state_d;
  logic [CB-1:0] cnt_q, cnt_d;
  logic [CB-1:0] ebit_q, ebit_d;
  logic          out_valid_q, out_valid_d;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ebit_d      = ebit_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    cmd_o.ebit  = ebit_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '1;
          ebit_d     = '1;
          if (status_i.exp_zero || status_i.mod_le1) begin
            state_d = S_FIN;
          end else begin
            state_d = S_RED;
          end
        end
      end
      S_RED: begin
        cmd_o.red_step = 1'b1;
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          state_d = S_LD_SQ;
        end
      end
      S_LD_SQ: begin
        cmd_o.ld_sq = 1'b1;
        cnt_d       = '1;
        state_d     = S_SQ;
      end
      S_SQ: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_last = (cnt_q == '0);
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (status_i.exp_bit) begin
            state_d = S_LD_MUL;
          end else if (ebit_q == '0) begin
            state_d = S_FIN;
          end else begin
            ebit_d  = ebit_q - 1'b1;
            state_d = S_LD_SQ;
          end
        end
      end
      S_LD_MUL: begin
        cmd_o.ld_mul = 1'b1;
        cnt_d        = '1;
        state_d      = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_last = (cnt_q == '0);
        cnt_d          = cnt_q - 1'b1;
        if (cnt_q == '0) begin
          if (ebit_q == '0) begin
            state_d = S_FIN;
          end else begin
            ebit_d  = ebit_q - 1'b1;
            state_d = S_LD_SQ;
          end
        end
      end
      S_FIN: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      ebit_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      ebit_q      <= ebit_d;
      out_valid_q <= out_valid_d;
    end
  end

  a_fin_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN && out_valid_q && !out_ready_i) |=> (state_q == S_FIN))
    else $error("finished request left FIN while the output was still full");

  a_red_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RED) |=> (state_q == S_RED || state_q == S_LD_SQ))
    else $error("base reduction left for an unexpected state");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_load |=> out_valid_q)
    else $error("result load did not raise the output valid");

  a_mul_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && cnt_q == '0) |=> (state_q == S_LD_SQ || state_q == S_FIN))
    else $error("multiply finished into an unexpected state");

endmodule

`default_nettype wire

/* hw/rtl/modular_exponentiation.sv */
// Channel  Direction  Handshake                 Payload
// in       input      in_valid_i / in_ready_o   in_data_i  (base_value, last_element)
// out      output     out_valid_o / out_ready_i out_data_o (power_result, last_out)
// cfg      input      cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// A request with a zero exponent or a modulus of at most one goes straight to
// the finish state. Otherwise the base is first reduced by the modulus, then
// each exponent bit from the top gets a squaring and, when set, a multiply,
// all on the one shift-and-add modular multiplier, one multiplier bit per cycle.
// Reset is asynchronous and active low; it clears the control state and sets
// the exponent to zero and the modulus to one.
// A new request is taken while a finished result waits in the output register.
`default_nettype none

module modular_exponentiation (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire mexp_pkg::in_req_t  in_data_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output mexp_pkg::out_req_t      out_data_o,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [0:0]         cfg_index_i,
  input  wire logic [31:0]        cfg_data_i
);

  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;

  assign cfg_ready_o = 1'b1;

  mexp_controller u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  mexp_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_write_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire
